FILE: rtl/core/rme_pkg.sv
// ----------------------------------------------------------------------------
// rme_pkg: shared types and constants of the rotation matrix to Euler core
// Holds the CORDIC arctangent table, lane layout and datapath widths.
// ----------------------------------------------------------------------------
package rme_pkg;

  // Default and largest number of CORDIC micro-rotations.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;

  // Square root: sixteen iterations, two per pipeline stage.
  localparam int SQRT_ITERS  = 16;
  localparam int SQRT_PER_ST = 2;
  localparam int SQRT_STAGES = SQRT_ITERS / SQRT_PER_ST;

  // CORDIC vector and angle widths.
  localparam int XW = 28;
  localparam int ZW = 36;

  // Lane numbers of the three arctangent datapaths.
  localparam int LANES      = 3;
  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  // Output angle limit, pi in Q3.13.
  localparam logic signed [15:0] ANGLE_MAX = 16'sd25736;

  // pi/2 in Q2.30.
  localparam logic signed [ZW-1:0] HALF_PI = 36'sh06487ED50;

  // atan(2^-i) in Q2.30, truncated.
  localparam logic [31:0] ATAN_TAB [CORDIC_STAGES_MAX] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  // The matrix entries that the conversion uses.
  typedef struct packed {
    logic signed [15:0] e00;
    logic signed [15:0] e10;
    logic signed [15:0] e20;
    logic signed [15:0] e21;
    logic signed [15:0] e22;
    logic signed [15:0] e12;
    logic signed [15:0] e11;
  } elems_t;

  // One CORDIC lane: vector, accumulated angle and zero-vector flag.
  typedef struct packed {
    logic                 zero;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } lane_t;

  typedef lane_t [LANES-1:0] lanes_t;

  // Negation that maps the most negative value to the most positive one.
  function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
    logic signed [15:0] r;
    if (v == -16'sd32768) begin
      r = 16'sd32767;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/rme_sqrt_stage.sv
// ----------------------------------------------------------------------------
// rme_sqrt_stage: one pipeline stage of the integer square root
// Runs two restoring digit iterations and carries the matrix entries along.
// ----------------------------------------------------------------------------
module rme_sqrt_stage #(
  parameter int BASE_ITER = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_in,
  input  logic [31:0]     rem_in,
  input  logic [31:0]     res_in,
  input  rme_pkg::elems_t elems_in,
  output logic            valid_out,
  output logic [31:0]     rem_out,
  output logic [31:0]     res_out,
  output rme_pkg::elems_t elems_out
);

  logic [31:0] rem_nxt;
  logic [31:0] res_nxt;
  logic        valid_r;
  logic [31:0] rem_r;
  logic [31:0] res_r;
  rme_pkg::elems_t elems_r;

  // Two iterations of the digit-by-digit root.
  always_comb begin
    logic [31:0] bitv;
    logic [31:0] trial;
    rem_nxt = rem_in;
    res_nxt = res_in;
    for (int j = 0; j < rme_pkg::SQRT_PER_ST; j++) begin
      bitv  = 32'd1 << (30 - 2 * (BASE_ITER + j));
      trial = res_nxt + bitv;
      if (rem_nxt >= trial) begin
        rem_nxt = rem_nxt - trial;
        res_nxt = (res_nxt >> 1) + bitv;
      end else begin
        res_nxt = res_nxt >> 1;
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    res_r   <= res_nxt;
    elems_r <= elems_in;
  end

  assign valid_out = valid_r;
  assign rem_out   = rem_r;
  assign res_out   = res_r;
  assign elems_out = elems_r;

endmodule

FILE: rtl/core/rme_cordic_stage.sv
// ----------------------------------------------------------------------------
// rme_cordic_stage: one vectoring CORDIC micro-rotation for all three lanes
// Each lane turns its vector toward the x axis by atan(2^-SHIFT).
// ----------------------------------------------------------------------------
module rme_cordic_stage #(
  parameter int SHIFT = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            valid_in,
  input  logic            sing_in,
  input  rme_pkg::lanes_t lanes_in,
  output logic            valid_out,
  output logic            sing_out,
  output rme_pkg::lanes_t lanes_out
);

  localparam logic signed [rme_pkg::ZW-1:0] ANGLE_STEP =
    rme_pkg::ZW'(rme_pkg::ATAN_TAB[SHIFT]);

  rme_pkg::lanes_t lanes_nxt;
  rme_pkg::lanes_t lanes_r;
  logic            valid_r;
  logic            sing_r;

  // Micro-rotation; both updates use the incoming x and y.
  always_comb begin
    logic signed [rme_pkg::XW-1:0] xs;
    logic signed [rme_pkg::XW-1:0] ys;
    for (int l = 0; l < rme_pkg::LANES; l++) begin
      xs = lanes_in[l].x >>> SHIFT;
      ys = lanes_in[l].y >>> SHIFT;
      lanes_nxt[l].zero = lanes_in[l].zero;
      if (lanes_in[l].y > 0) begin
        lanes_nxt[l].x = lanes_in[l].x + ys;
        lanes_nxt[l].y = lanes_in[l].y - xs;
        lanes_nxt[l].z = lanes_in[l].z + ANGLE_STEP;
      end else begin
        lanes_nxt[l].x = lanes_in[l].x - ys;
        lanes_nxt[l].y = lanes_in[l].y + xs;
        lanes_nxt[l].z = lanes_in[l].z - ANGLE_STEP;
      end
    end
  end

  // Stage valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
    sing_r  <= sing_in;
  end

  assign valid_out = valid_r;
  assign sing_out  = sing_r;
  assign lanes_out = lanes_r;

endmodule

FILE: rtl/core/rotation_matrix_to_euler_core.sv
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// The rate is set by the fully unrolled square root and CORDIC pipelines.
// Reset clears all valid bits; the threshold register thr_r returns to 1.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_core: rotation matrix to XYZ Euler angles
// Square root of r00^2 + r10^2, then three parallel vectoring CORDIC lanes.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_core #(
  parameter int CORDIC_STAGES = rme_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_elem_00,
  input  logic signed [15:0] in_elem_10,
  input  logic signed [15:0] in_elem_20,
  input  logic signed [15:0] in_elem_21,
  input  logic signed [15:0] in_elem_22,
  input  logic signed [15:0] in_elem_12,
  input  logic signed [15:0] in_elem_11,
  output logic               out_valid,
  output logic signed [15:0] out_roll_angle,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_is_singular,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data
);

  localparam int LATENCY = 13 + CORDIC_STAGES;

  // Configuration register.
  logic [14:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= 15'd1;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Input register.
  logic            v0_r;
  rme_pkg::elems_t e0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    e0_r <= '{e00: in_elem_00, e10: in_elem_10, e20: in_elem_20, e21: in_elem_21,
              e22: in_elem_22, e12: in_elem_12, e11: in_elem_11};
  end

  // Squares of r00 and r10.
  logic            v1_r;
  rme_pkg::elems_t e1_r;
  logic [31:0]     sq00_r;
  logic [31:0]     sq10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    sq00_r <= 32'(e0_r.e00 * e0_r.e00);
    sq10_r <= 32'(e0_r.e10 * e0_r.e10);
    e1_r   <= e0_r;
  end

  // Sum of squares, Q2.28.
  logic            v2_r;
  rme_pkg::elems_t e2_r;
  logic [31:0]     sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sq00_r + sq10_r;
    e2_r  <= e1_r;
  end

  // Square root pipeline.
  logic            sv   [rme_pkg::SQRT_STAGES+1];
  logic [31:0]     srem [rme_pkg::SQRT_STAGES+1];
  logic [31:0]     sres [rme_pkg::SQRT_STAGES+1];
  rme_pkg::elems_t se   [rme_pkg::SQRT_STAGES+1];

  assign sv[0]   = v2_r;
  assign srem[0] = sum_r;
  assign sres[0] = 32'd0;
  assign se[0]   = e2_r;

  for (genvar s = 0; s < rme_pkg::SQRT_STAGES; s++) begin : g_sqrt
    rme_sqrt_stage #(
      .BASE_ITER(s * rme_pkg::SQRT_PER_ST)
    ) u_sqrt (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (sv[s]),
      .rem_in   (srem[s]),
      .res_in   (sres[s]),
      .elems_in (se[s]),
      .valid_out(sv[s+1]),
      .rem_out  (srem[s+1]),
      .res_out  (sres[s+1]),
      .elems_out(se[s+1])
    );
  end

  // Lane setup: scale by 256 and pre-rotate left-half vectors.
  function automatic rme_pkg::lane_t lane_init(input logic signed [17:0] y,
                                               input logic signed [17:0] x);
    rme_pkg::lane_t                 ln;
    logic signed [rme_pkg::XW-1:0] xw;
    logic signed [rme_pkg::XW-1:0] yw;
    xw = {{(rme_pkg::XW-26){x[17]}}, x, 8'b0};
    yw = {{(rme_pkg::XW-26){y[17]}}, y, 8'b0};
    ln.zero = (x == 18'sd0) && (y == 18'sd0);
    if (x < 0) begin
      if (y >= 0) begin
        ln.x = yw;
        ln.y = -xw;
        ln.z = rme_pkg::HALF_PI;
      end else begin
        ln.x = -yw;
        ln.y = xw;
        ln.z = -rme_pkg::HALF_PI;
      end
    end else begin
      ln.x = xw;
      ln.y = yw;
      ln.z = '0;
    end
    return ln;
  endfunction

  // Singular test and lane selection.
  rme_pkg::elems_t se_l;
  logic [15:0]     sy;
  logic            sing_nxt;
  rme_pkg::lanes_t lanes_nxt;
  logic            vs_r;
  logic            sing_r;
  rme_pkg::lanes_t lanes_r;

  assign se_l     = se[rme_pkg::SQRT_STAGES];
  assign sy       = sres[rme_pkg::SQRT_STAGES][15:0];
  assign sing_nxt = {1'b0, sy} < {2'b00, thr_r};

  always_comb begin
    lanes_nxt[rme_pkg::LANE_PITCH] =
      lane_init(18'(rme_pkg::neg_sat(se_l.e20)), {2'b00, sy});
    lanes_nxt[rme_pkg::LANE_YAW] = lane_init(18'(se_l.e10), 18'(se_l.e00));
    if (sing_nxt) begin
      lanes_nxt[rme_pkg::LANE_ROLL] =
        lane_init(18'(rme_pkg::neg_sat(se_l.e12)), 18'(se_l.e11));
    end else begin
      lanes_nxt[rme_pkg::LANE_ROLL] = lane_init(18'(se_l.e21), 18'(se_l.e22));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r <= 1'b0;
    end else begin
      vs_r <= sv[rme_pkg::SQRT_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    sing_r  <= sing_nxt;
    lanes_r <= lanes_nxt;
  end

  // CORDIC pipeline.
  logic            cv [CORDIC_STAGES+1];
  logic            cs [CORDIC_STAGES+1];
  rme_pkg::lanes_t cl [CORDIC_STAGES+1];

  assign cv[0] = vs_r;
  assign cs[0] = sing_r;
  assign cl[0] = lanes_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    rme_cordic_stage #(
      .SHIFT(i)
    ) u_cordic (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_in (cv[i]),
      .sing_in  (cs[i]),
      .lanes_in (cl[i]),
      .valid_out(cv[i+1]),
      .sing_out (cs[i+1]),
      .lanes_out(cl[i+1])
    );
  end

  // Round Q2.30 to Q3.13 and saturate.
  function automatic logic signed [15:0] to_angle(input rme_pkg::lane_t ln);
    logic signed [rme_pkg::ZW-1:0] q;
    logic signed [15:0]            r;
    q = (ln.z + rme_pkg::ZW'(65536)) >>> 17;
    if (ln.zero) begin
      r = 16'sd0;
    end else if (q > rme_pkg::ZW'(rme_pkg::ANGLE_MAX)) begin
      r = rme_pkg::ANGLE_MAX;
    end else if (q < -rme_pkg::ZW'(rme_pkg::ANGLE_MAX)) begin
      r = -rme_pkg::ANGLE_MAX;
    end else begin
      r = q[15:0];
    end
    return r;
  endfunction

  // Output register.
  logic               out_valid_r;
  logic signed [15:0] roll_r;
  logic signed [15:0] pitch_r;
  logic signed [15:0] yaw_r;
  logic               osing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cv[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    roll_r  <= to_angle(cl[CORDIC_STAGES][rme_pkg::LANE_ROLL]);
    pitch_r <= to_angle(cl[CORDIC_STAGES][rme_pkg::LANE_PITCH]);
    yaw_r   <= cs[CORDIC_STAGES] ? 16'sd0 :
               to_angle(cl[CORDIC_STAGES][rme_pkg::LANE_YAW]);
    osing_r <= cs[CORDIC_STAGES];
  end

  assign out_valid       = out_valid_r;
  assign out_roll_angle  = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle   = yaw_r;
  assign out_is_singular = osing_r;

`ifndef SYNTH
  // Every accepted request yields a result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after fixed latency");

  // Every result comes from a request accepted the fixed latency earlier.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without a request");

  // The singular path forces yaw to zero.
  a_sing_yaw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_singular) |-> (out_yaw_angle == 16'sd0))
    else $error("nonzero yaw on singular result");

  // Pitch stays within plus or minus pi.
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pitch_angle <= 16'sd25736 && out_pitch_angle >= -16'sd25736))
    else $error("pitch out of range");
`endif

endmodule

FILE: sim/tb_rotation_matrix_to_euler_core.sv
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_euler_core: self-checking bench of the Euler core
// Drives matrix requests with random gaps, predicts the three angles and the
// singular flag with a bit-exact CORDIC model, and checks every result.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_euler_core;

  localparam int STAGES     = rme_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY    = 13 + STAGES;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               sing;
  } angles_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [15:0] in_elem_00, in_elem_10, in_elem_20, in_elem_21;
  logic signed [15:0] in_elem_22, in_elem_12, in_elem_11;
  logic out_valid;
  logic signed [15:0] out_roll_angle, out_pitch_angle, out_yaw_angle;
  logic out_is_singular;
  logic cfg_valid;
  logic cfg_ready;
  logic [14:0] cfg_data;

  angles_t pending_angles[$];
  logic [14:0] model_threshold;
  int failures = 0;
  int cycles = 0;
  bit idle_enable;

  rotation_matrix_to_euler_core DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_elem_00(in_elem_00), .in_elem_10(in_elem_10), .in_elem_20(in_elem_20),
    .in_elem_21(in_elem_21), .in_elem_22(in_elem_22), .in_elem_12(in_elem_12),
    .in_elem_11(in_elem_11), .out_valid(out_valid),
    .out_roll_angle(out_roll_angle), .out_pitch_angle(out_pitch_angle),
    .out_yaw_angle(out_yaw_angle), .out_is_singular(out_is_singular),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Clock with a period of two time units.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Cycle counter and timeout guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL rotation_matrix_to_euler_core");
      $finish;
    end
  end

  // Saturating negation of a matrix entry.
  function automatic longint negate_entry(input longint v);
    return (v == -32768) ? 32767 : -v;
  endfunction

  // Vectoring CORDIC arctangent, rounded to Q3.13 and clamped to +-pi.
  function automatic logic signed [15:0] cordic_angle(input longint y_in,
                                                      input longint x_in);
    longint x, y, z, t, xs, ys, q;
    x = x_in * 256;
    y = y_in * 256;
    z = 0;
    if (x_in == 0 && y_in == 0) return 16'sd0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 64'sh3243F6A8 * 2;
      end else begin
        x = -y; y = t; z = -(64'sh3243F6A8 * 2);
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(rme_pkg::ATAN_TAB[i]);
      end else begin
        x -= ys; y += xs; z -= longint'(rme_pkg::ATAN_TAB[i]);
      end
    end
    q = (z + 65536) >>> 17;
    if (q > 25736) q = 25736;
    if (q < -25736) q = -25736;
    return q[15:0];
  endfunction

  // Predict the Euler angles of one matrix request.
  function automatic angles_t euler_from_matrix(input rme_pkg::elems_t m);
    angles_t a;
    longint sum, sy;
    sum = longint'(m.e00) * m.e00 + longint'(m.e10) * m.e10;
    sy = 0;
    while ((sy + 1) * (sy + 1) <= sum) sy++;
    a.sing = (sy < longint'(model_threshold));
    a.pitch = cordic_angle(negate_entry(m.e20), sy);
    if (!a.sing) begin
      a.roll = cordic_angle(m.e21, m.e22);
      a.yaw = cordic_angle(m.e10, m.e00);
    end else begin
      a.roll = cordic_angle(negate_entry(m.e12), m.e11);
      a.yaw = 16'sd0;
    end
    return a;
  endfunction

  // Compare every result with the oldest prediction.
  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_valid) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected result");
        failures++;
      end else begin
        e = pending_angles.pop_front();
        if (out_roll_angle !== e.roll) begin
          $error("roll_angle expected %0d got %0d", e.roll, out_roll_angle);
          failures++;
        end
        if (out_pitch_angle !== e.pitch) begin
          $error("pitch_angle expected %0d got %0d", e.pitch, out_pitch_angle);
          failures++;
        end
        if (out_yaw_angle !== e.yaw) begin
          $error("yaw_angle expected %0d got %0d", e.yaw, out_yaw_angle);
          failures++;
        end
        if (out_is_singular !== e.sing) begin
          $error("is_singular expected %0d got %0d", e.sing, out_is_singular);
          failures++;
        end
      end
    end
  end

  // Random idle burst before a request.
  task automatic idle_gap();
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Send one matrix request and record its prediction.
  task automatic send_matrix(input rme_pkg::elems_t m);
    idle_gap();
    start <= 1'b1;
    in_elem_00 <= m.e00; in_elem_10 <= m.e10; in_elem_20 <= m.e20;
    in_elem_21 <= m.e21; in_elem_22 <= m.e22; in_elem_12 <= m.e12;
    in_elem_11 <= m.e11;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_angles.insert(pending_angles.size(), euler_from_matrix(m));
  endtask

  // Wait until every prediction has been matched and the pipe is empty.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Write the threshold while the core is idle.
  task automatic write_threshold(input logic [14:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_threshold = v;
  endtask

  function automatic rme_pkg::elems_t random_matrix();
    rme_pkg::elems_t m;
    logic [127:0] rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom};
    m = rnd[111:0];
    return m;
  endfunction

  // Plausible matrix: every entry within the unit range; one time in four r00 and r10 are near zero.
  function automatic rme_pkg::elems_t plausible_matrix();
    rme_pkg::elems_t m;
    m.e00 = 16'($urandom_range(0, 32768) - 16384);
    m.e10 = 16'($urandom_range(0, 32768) - 16384);
    m.e20 = 16'($urandom_range(0, 32768) - 16384);
    m.e21 = 16'($urandom_range(0, 32768) - 16384);
    m.e22 = 16'($urandom_range(0, 32768) - 16384);
    m.e12 = 16'($urandom_range(0, 32768) - 16384);
    m.e11 = 16'($urandom_range(0, 32768) - 16384);
    if ($urandom_range(0, 3) == 0) begin
      m.e00 = 16'($urandom_range(0, 600) - 300);
      m.e10 = 16'($urandom_range(0, 600) - 300);
    end
    return m;
  endfunction

  // Field extremes, zero vectors, saturated negation and the singular path.
  task automatic test_directed();
    logic signed [15:0] ext[4] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd1};
    rme_pkg::elems_t m;
    send_matrix('0);
    send_matrix({7{16'sh8000}});
    send_matrix({7{16'sh7FFF}});
    send_matrix({7{16'shFFFF}});
    send_matrix({16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384});
    send_matrix({16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0, 16'sh8000, 16'sd16384});
    send_matrix({16'sd0, 16'sd0, 16'sd16384, 16'sd5, 16'sd7, 16'sd0, 16'sd0});
    for (int i = 0; i < 16; i++) begin
      m = random_matrix();
      m.e00 = ext[i % 4]; m.e10 = ext[i / 4];
      m.e22 = ext[(i + 1) % 4]; m.e11 = ext[(i + 2) % 4];
      send_matrix(m);
    end
    drain();
  endtask

  // One threshold setting followed by random requests.
  task automatic test_random(input logic [14:0] thr, input int count);
    write_threshold(thr);
    for (int i = 0; i < count; i++) begin
      send_matrix(($urandom_range(0, 4) == 0) ? random_matrix() : plausible_matrix());
    end
    drain();
  endtask

  // Back-to-back requests with no idling.
  task automatic test_streaming(input int count);
    idle_enable = 1'b0;
    for (int i = 0; i < count; i++) send_matrix(plausible_matrix());
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    {in_elem_00, in_elem_10, in_elem_20, in_elem_21} <= '0;
    {in_elem_22, in_elem_12, in_elem_11} <= '0;
    idle_enable = 1'b1;
    model_threshold = 15'd1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(15'd0, 250);
    test_random(15'd16384, 350);
    test_random(15'd32767, 250);
    test_random(15'd200, 350);
    test_random(15'($urandom_range(0, 32767)), 200);
    test_random(15'd1, 100);
    test_streaming(250);
    if (failures == 0) begin
      $display("PASS rotation_matrix_to_euler_core");
    end else begin
      $display("FAIL rotation_matrix_to_euler_core");
    end
    $finish;
  end

endmodule
